// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent that implies a consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/i2cw_pkg.sv =====
// Types and constants for the I2C register-write master.
// No dependencies; used by every module of the block.
package i2cw_pkg;

  typedef struct packed {
    logic       go;
    logic [7:0] reg_addr;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       last_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic scl;
    logic sda_drive_low;
    logic need_data;
    logic busy_res;
    logic nack_seen;
    logic done_res;
  } out_item_t;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_ADDR  = 8'b0000_0010,
    PH_REG   = 8'b0000_0100,
    PH_WAIT  = 8'b0000_1000,
    PH_DATA  = 8'b0001_0000,
    PH_STOP1 = 8'b0010_0000,
    PH_STOP2 = 8'b0100_0000,
    PH_STOP3 = 8'b1000_0000
  } phase_t;

  localparam logic [3:0] ACK_SLOT       = 4'd8;
  localparam logic [6:0] DEV_ADDR_RESET = 7'h1B;

endpackage

// ===== rtl/i2c_master_register_write.sv =====
// A request is accepted into the front holding register, passes through the request queue, and its
// result is registered in the result register of the bus sequencer when the queue entry is popped.
// Throughput: one request per cycle while neither the queue nor the result channel stalls.
// The front holding register, the request queue and the result register let each side stall.
// Reset (rst_n low, synchronous) empties the queue, idles the bus and sets the address to 0x1B.
// Depends on i2cw_pkg, i2cw_front, i2cw_queue, i2cw_back and assert_macros.svh.
`include "assert_macros.svh"

module i2c_master_register_write #(
  parameter int QDEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  // Request channel: one half-bit tick of the bus per request.
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cw_pkg::in_item_t  in_item,
  // Result channel: one result per request, in order.
  output logic                out_valid,
  input  logic                out_stall,
  output i2cw_pkg::out_item_t out_item,
  // Device address register write port.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);

  logic               push;
  i2cw_pkg::in_item_t push_item;
  logic               q_full;
  logic               pop;
  logic               q_valid;
  i2cw_pkg::in_item_t q_item;
  logic [6:0]         dev_addr_r;

  // The address is sampled only when a transfer starts, so a write is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= i2cw_pkg::DEV_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr_r <= cfg_data;
    end
  end

  // The front takes requests in as long as the queue drains.
  i2cw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  i2cw_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // The back runs the bus state machine and holds the result until it is taken.
  i2cw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dev_addr  (dev_addr_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // An idle tick leaves the bus released.
  `ASSERT_IMPLIES(a_idle_released, clk, rst_n, out_valid && !out_item.busy_res,
    out_item.scl && !out_item.sda_drive_low && !out_item.done_res, "idle tick drives bus")
  // A byte is taken only while the clock is held low.
  `ASSERT_IMPLIES(a_need_scl_low, clk, rst_n, out_valid && out_item.need_data,
    !out_item.scl && !out_item.sda_drive_low && out_item.busy_res, "data taken with scl high")
  // The stop completes with the clock high and SDA released.
  `ASSERT_IMPLIES(a_done_stop, clk, rst_n, out_valid && out_item.done_res,
    out_item.scl && !out_item.sda_drive_low && out_item.busy_res, "bad stop condition")
  // The sequencer only advances when a request is queued.
  `ASSERT_IMPLIES(a_pop_has_item, clk, rst_n, pop, q_valid, "pop from empty queue")

endmodule

// ===== rtl/i2cw_front.sv =====
// Front stage: takes requests from the input channel into a holding register.
// Depends on i2cw_pkg; feeds i2cw_queue.
module i2cw_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  i2cw_pkg::in_item_t in_item,
  output logic               push,
  output i2cw_pkg::in_item_t push_item,
  input  logic               q_full
);

  logic               hold_valid_r;
  logic               hold_valid_nxt;
  i2cw_pkg::in_item_t hold_item_r;
  logic               take;

  // The holding slot drains into the queue whenever the queue has room.
  assign push      = hold_valid_r && !q_full;
  assign push_item = hold_item_r;
  assign in_stall  = hold_valid_r && q_full;
  assign take      = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (take) begin
      hold_valid_nxt = 1'b1;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_item_r <= in_item;
    end
  end

endmodule

// ===== rtl/i2cw_queue.sv =====
// Short request queue between the front stage and the bus sequencer.
// Depends on i2cw_pkg.
module i2cw_queue #(
  parameter int QDEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  i2cw_pkg::in_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output i2cw_pkg::in_item_t q_item
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR  = PW'(QDEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QDEPTH);

  i2cw_pkg::in_item_t slot_r [QDEPTH];
  logic [PW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == DEPTH_CNT);
  assign q_valid = (count_r != '0);
  assign q_item  = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/i2cw_back.sv =====
// Bus sequencer: runs one half-bit tick per request and registers the result.
// Depends on i2cw_pkg; fed by i2cw_queue.
module i2cw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [6:0]          dev_addr,
  input  logic                q_valid,
  input  i2cw_pkg::in_item_t  q_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cw_pkg::out_item_t out_item
);

  i2cw_pkg::phase_t    phase_r, phase_nxt;
  logic                half_r, half_nxt;
  logic [3:0]          bit_r, bit_nxt;
  logic [7:0]          shift_r, shift_nxt;
  logic [7:0]          held_r, held_nxt;
  logic                final_r, final_nxt;
  logic                nack_r, nack_nxt;
  logic                out_valid_r, out_valid_nxt;
  i2cw_pkg::out_item_t out_r, res;

  assign pop       = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    phase_nxt = phase_r;
    half_nxt  = half_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    held_nxt  = held_r;
    final_nxt = final_r;
    nack_nxt  = nack_r;
    res.scl           = 1'b1;
    res.sda_drive_low = 1'b0;
    res.need_data     = 1'b0;
    res.busy_res      = 1'b1;
    res.done_res      = 1'b0;

    case (phase_r)
      i2cw_pkg::PH_ADDR, i2cw_pkg::PH_REG, i2cw_pkg::PH_DATA: begin
        res.scl = half_r;
        res.sda_drive_low = (bit_r < i2cw_pkg::ACK_SLOT) ? !shift_r[7] : 1'b0;
        if (!half_r) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt = 1'b0;
          if (bit_r < i2cw_pkg::ACK_SLOT) begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_r + 4'd1;
          end else begin
            // High half of the acknowledge clock.
            if (q_item.sda_in) begin
              nack_nxt = 1'b1;
            end
            bit_nxt = '0;
            if (phase_r == i2cw_pkg::PH_ADDR) begin
              shift_nxt = held_r;
              phase_nxt = i2cw_pkg::PH_REG;
            end else if (phase_r == i2cw_pkg::PH_REG) begin
              phase_nxt = i2cw_pkg::PH_WAIT;
            end else begin
              phase_nxt = final_r ? i2cw_pkg::PH_STOP1 : i2cw_pkg::PH_WAIT;
            end
          end
        end
      end
      i2cw_pkg::PH_WAIT: begin
        res.scl = 1'b0;
        if (q_item.data_valid) begin
          res.need_data = 1'b1;
          shift_nxt = q_item.data_byte;
          final_nxt = q_item.last_byte;
          bit_nxt   = '0;
          half_nxt  = 1'b0;
          phase_nxt = i2cw_pkg::PH_DATA;
        end
      end
      i2cw_pkg::PH_STOP1: begin
        res.scl = 1'b0;
        res.sda_drive_low = 1'b1;
        phase_nxt = i2cw_pkg::PH_STOP2;
      end
      i2cw_pkg::PH_STOP2: begin
        res.sda_drive_low = 1'b1;
        phase_nxt = i2cw_pkg::PH_STOP3;
      end
      i2cw_pkg::PH_STOP3: begin
        res.done_res = 1'b1;
        phase_nxt = i2cw_pkg::PH_IDLE;
      end
      default: begin
        phase_nxt = i2cw_pkg::PH_IDLE;
        if (q_item.go) begin
          res.sda_drive_low = 1'b1;
          nack_nxt  = 1'b0;
          held_nxt  = q_item.reg_addr;
          shift_nxt = {dev_addr, 1'b0};
          final_nxt = 1'b0;
          bit_nxt   = '0;
          half_nxt  = 1'b0;
          phase_nxt = i2cw_pkg::PH_ADDR;
        end else begin
          res.busy_res = 1'b0;
        end
      end
    endcase
    res.nack_seen = nack_nxt;

    out_valid_nxt = pop || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cw_pkg::PH_IDLE;
      half_r      <= 1'b0;
      bit_r       <= '0;
      shift_r     <= '0;
      held_r      <= '0;
      final_r     <= 1'b0;
      nack_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r <= phase_nxt;
        half_r  <= half_nxt;
        bit_r   <= bit_nxt;
        shift_r <= shift_nxt;
        held_r  <= held_nxt;
        final_r <= final_nxt;
        nack_r  <= nack_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
  end

endmodule

// ===== tb/sv/i2c_master_register_write_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the I2C register-write master: it drives half-bit ticks,
// predicts every line state and compares each result in order.
// Depends on i2cw_pkg and the i2c_master_register_write RTL.

module i2c_master_register_write_test;

  // Cycles in which no channel moves anything before the run is declared hung.
  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_TICKS = 700;

  // Bus-level predictor and result store. Each accepted request is run
  // through a cycle-accurate copy of the sequencer, and the line state that
  // it should produce is queued until the block returns it.
  class i2c_line_checker;
    i2cw_pkg::phase_t    state;
    logic                high_half;
    logic [3:0]          bit_count;
    logic [7:0]          shifter;
    logic [7:0]          held_reg;
    logic                final_byte;
    logic                nack;
    logic [6:0]          dev_addr;
    i2cw_pkg::out_item_t expected_lines[$];
    int                  errors;

    function new();
      state      = i2cw_pkg::PH_IDLE;
      high_half  = 1'b0;
      bit_count  = '0;
      shifter    = '0;
      held_reg   = '0;
      final_byte = 1'b0;
      nack       = 1'b0;
      dev_addr   = i2cw_pkg::DEV_ADDR_RESET;
      errors     = 0;
    endfunction

    function void set_device_address(logic [6:0] a);
      dev_addr = a;
    endfunction

    function bit is_idle();
      return state == i2cw_pkg::PH_IDLE;
    endfunction

    function bit is_waiting();
      return state == i2cw_pkg::PH_WAIT;
    endfunction

    function int pending();
      return expected_lines.size();
    endfunction

    // Advance the predicted sequencer by one half-bit tick.
    function void take_tick(i2cw_pkg::in_item_t t);
      i2cw_pkg::out_item_t e;
      e = '0;
      e.scl = 1'b1;
      e.busy_res = 1'b1;
      case (state)
        i2cw_pkg::PH_ADDR, i2cw_pkg::PH_REG, i2cw_pkg::PH_DATA: begin
          e.scl = high_half;
          // Data bits drive the MSB; the ack slot releases SDA.
          e.sda_drive_low = (bit_count < i2cw_pkg::ACK_SLOT) ? ~shifter[7] : 1'b0;
          if (!high_half) begin
            high_half = 1'b1;
          end else begin
            high_half = 1'b0;
            if (bit_count < i2cw_pkg::ACK_SLOT) begin
              shifter = shifter << 1;
              bit_count = bit_count + 4'd1;
            end else begin
              if (t.sda_in) nack = 1'b1;
              bit_count = '0;
              if (state == i2cw_pkg::PH_ADDR) begin
                shifter = held_reg;
                state = i2cw_pkg::PH_REG;
              end else if (state == i2cw_pkg::PH_REG) begin
                state = i2cw_pkg::PH_WAIT;
              end else begin
                state = final_byte ? i2cw_pkg::PH_STOP1 : i2cw_pkg::PH_WAIT;
              end
            end
          end
        end
        i2cw_pkg::PH_WAIT: begin
          e.scl = 1'b0;
          if (t.data_valid) begin
            e.need_data = 1'b1;
            shifter = t.data_byte;
            final_byte = t.last_byte;
            bit_count = '0;
            high_half = 1'b0;
            state = i2cw_pkg::PH_DATA;
          end
        end
        i2cw_pkg::PH_STOP1: begin
          e.scl = 1'b0;
          e.sda_drive_low = 1'b1;
          state = i2cw_pkg::PH_STOP2;
        end
        i2cw_pkg::PH_STOP2: begin
          e.sda_drive_low = 1'b1;
          state = i2cw_pkg::PH_STOP3;
        end
        i2cw_pkg::PH_STOP3: begin
          e.done_res = 1'b1;
          state = i2cw_pkg::PH_IDLE;
        end
        default: begin
          state = i2cw_pkg::PH_IDLE;
          if (t.go) begin
            // Start condition: SDA falls while SCL is high.
            e.sda_drive_low = 1'b1;
            nack = 1'b0;
            held_reg = t.reg_addr;
            shifter = {dev_addr, 1'b0};
            final_byte = 1'b0;
            bit_count = '0;
            high_half = 1'b0;
            state = i2cw_pkg::PH_ADDR;
          end else begin
            e.busy_res = 1'b0;
          end
        end
      endcase
      e.nack_seen = nack;
      expected_lines.push_back(e);
    endfunction

    function void compare_field(string name, logic e, logic a);
      if (e !== a) begin
        errors++;
        $display("%0t: mismatch on %s: expected %b, actual %b", $time, name, e, a);
      end
    endfunction

    function void check_line(i2cw_pkg::out_item_t got);
      i2cw_pkg::out_item_t e;
      if (expected_lines.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: actual %b", $time, got);
        return;
      end
      e = expected_lines.pop_front();
      compare_field("scl", e.scl, got.scl);
      compare_field("sda_drive_low", e.sda_drive_low, got.sda_drive_low);
      compare_field("need_data", e.need_data, got.need_data);
      compare_field("busy_res", e.busy_res, got.busy_res);
      compare_field("nack_seen", e.nack_seen, got.nack_seen);
      compare_field("done_res", e.done_res, got.done_res);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  i2cw_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  i2cw_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [6:0]          cfg_data = '0;

  i2c_line_checker lines = new();

  // Sender pacing state: requests go out in bursts separated by gaps.
  int burst_left = 0;
  int ticks_sent = 0;
  int idle_cycles = 0;

  i2c_master_register_write dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Every result that the receiver takes is checked against the oldest
  // prediction. Sampling happens at the rising edge, before the block's own
  // registers update, so the values seen are the ones that were handshaked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      lines.check_line(out_item);
    end
  end

  // The receiver switches between three stall patterns: no stalls at all,
  // independent random stalls, and long alternating runs of stall and go.
  int  pattern_left = 0;
  int  pattern_mode = 0;
  int  run_left = 0;
  logic run_level = 1'b0;
  always @(negedge clk) begin
    if (pattern_left == 0) begin
      pattern_mode = $urandom_range(0, 2);
      pattern_left = $urandom_range(20, 200);
    end
    pattern_left--;
    case (pattern_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 35);
      default: begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 16);
          run_level = ~run_level;
        end
        run_left--;
        out_stall <= run_level;
      end
    endcase
  end

  // Watchdog: a correct run never goes this long without some channel
  // completing a handshake, whatever the stalls and gaps.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("i2c_master_register_write_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one request. Between bursts the valid line drops for a random gap;
  // inside a burst it stays high from one request to the next. The request
  // is noted for prediction at the edge where it is accepted.
  task automatic send_tick(input i2cw_pkg::in_item_t t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lines.take_tick(t);
    burst_left--;
    ticks_sent++;
  endtask

  // Hold off the sender until every predicted result has come back. This is
  // the only point where the address register may be rewritten.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (lines.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_address(input logic [6:0] a);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    lines.set_device_address(a);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One whole write transaction, steered by the predicted bus phase: go is
  // raised when the bus is idle and payload is offered while the block waits
  // for data. With noise on, go is also raised while busy, payload fields
  // toggle outside the wait, and the wait sometimes sees no data or a last
  // marker without valid. A few idle ticks with go low come first, so the
  // sticky nack flag of the previous transaction is seen after its stop.
  task automatic run_transfer(input logic [7:0] reg_byte, input int n_bytes,
                              input int nack_pct, input bit noisy, input bit random_data);
    i2cw_pkg::in_item_t t;
    logic [31:0]        noise;
    int                 sent;
    bit                 started;
    sent = 0;
    started = 0;
    repeat ($urandom_range(1, 3)) begin
      noise = $urandom;
      t = noise[$bits(i2cw_pkg::in_item_t)-1:0];
      t.go = 1'b0;
      send_tick(t);
    end
    while (!(started && lines.is_idle())) begin
      noise = $urandom;
      t = noise[$bits(i2cw_pkg::in_item_t)-1:0];
      if (!noisy) begin
        t.go = 1'b0;
        t.data_valid = 1'b0;
        t.last_byte = 1'b0;
      end
      if (lines.is_idle()) begin
        t.go = 1'b1;
        t.reg_addr = reg_byte;
        started = 1;
      end else if (lines.is_waiting()) begin
        if (noisy && $urandom_range(0, 3) == 0) begin
          t.data_valid = 1'b0;
        end else begin
          t.data_valid = 1'b1;
          t.data_byte = random_data ? 8'($urandom) : (sent[0] ? 8'h00 : 8'hFF);
          t.last_byte = (sent == n_bytes - 1);
          sent++;
        end
      end
      t.sda_in = ($urandom_range(0, 99) < nack_pct);
      send_tick(t);
    end
  endtask

  initial begin
    int         transfers;
    int         random_start;
    logic [6:0] next_addr;
    transfers = 0;

    // Synchronous reset, held from the start and then released for good.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The first transaction runs at the reset address with
    // every byte acknowledged and the smallest register byte.
    run_transfer(8'h00, 1, 0, 1'b0, 1'b0);

    // Address zero, every acknowledge missing, go held while busy, stray
    // payload outside the wait, and a stall in the wait with no data.
    settle();
    write_address(7'h00);
    run_transfer(8'hFF, 2, 100, 1'b1, 1'b0);

    // A fresh go must clear the nack flag left over from the last one.
    run_transfer(8'h5A, 1, 0, 1'b0, 1'b0);

    // Highest address, a longer payload, and a mix of ack and nack.
    settle();
    write_address(7'h7F);
    run_transfer(8'hA5, 3, 50, 1'b1, 1'b0);

    // Random part: mostly short well-formed transactions with random
    // content and noise, now and then a long payload. Every few
    // transactions the sender drains and the address changes, often to
    // an extreme or back to its reset value.
    random_start = ticks_sent;
    while (ticks_sent - random_start < RANDOM_TICKS) begin
      if (transfers % 4 == 0) begin
        settle();
        case ($urandom_range(0, 3))
          0: next_addr = 7'h00;
          1: next_addr = 7'h7F;
          2: next_addr = i2cw_pkg::DEV_ADDR_RESET;
          default: next_addr = 7'($urandom);
        endcase
        write_address(next_addr);
      end
      run_transfer(8'($urandom),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3),
                   ($urandom_range(0, 4) == 0) ? 60 : 10,
                   ($urandom_range(0, 3) != 0), 1'b1);
      transfers++;
    end

    // Let the last results drain; the watchdog bounds this wait.
    @(negedge clk);
    in_valid <= 1'b0;
    while (lines.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (lines.errors == 0 && lines.pending() == 0) begin
      $display("i2c_master_register_write_test passed");
    end else begin
      $display("i2c_master_register_write_test failed");
    end
    $finish;
  end

endmodule
